@@ design/tcfsm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcfsm_pkg
// Shared types and codes for the transport connection table.
// ----------------------------------------------------------------------------
package tcfsm_pkg;

   // action codes carried in the request
   localparam logic [2:0] ACT_OPEN     = 3'd0;
   localparam logic [2:0] ACT_LISTEN   = 3'd1;
   localparam logic [2:0] ACT_CLOSE    = 3'd2;
   localparam logic [2:0] ACT_SEGMENT  = 3'd3;
   localparam logic [2:0] ACT_TICK     = 3'd4;
   localparam logic [2:0] ACT_LINKDOWN = 3'd5;

   // segment types
   localparam logic [2:0] SEG_SYN    = 3'd0;
   localparam logic [2:0] SEG_SYNACK = 3'd1;
   localparam logic [2:0] SEG_FIN    = 3'd2;
   localparam logic [2:0] SEG_FINACK = 3'd3;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_NOENT = 2'd2,
      STS_WRONG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CS_CLOSED    = 2'd0,
      CS_LISTENING = 2'd1,
      CS_CONNECTED = 2'd2,
      CS_CLOSEWAIT = 2'd3
   } conn_state_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_DIRECT,
      CTL_POST
   } ctl_state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  socket_index;
      logic [15:0] local_port;
      logic [2:0]  seg_type;
      logic [15:0] seg_src_port;
      logic [15:0] seg_dest_port;
   } item_type;

   typedef struct packed {
      status_type     status;
      logic [2:0]     entry_index;
      conn_state_type entry_state;
      logic           reply_valid;
      logic [2:0]     reply_type;
      logic [15:0]    reply_src_port;
      logic [15:0]    reply_dest_port;
   } res_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request beat, clear the result
      logic rd_en;     // issue a table read
      logic chk_en;    // evaluate the entry in the read stage
      logic direct;    // execute listen/close on the addressed entry
      logic rsp_load;  // move the result into the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done; // walk finished: entry matched or last entry seen
   } stat_type;

endpackage
`default_nettype wire

@@ design/tcfsm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcfsm_ctrl
// Sequencer: accepts a request, walks the table or runs a direct access (an
// unknown action does neither), then hands the result to the output register.
// ----------------------------------------------------------------------------
module tcfsm_ctrl #(
   parameter int ENTRIES = 8,
   parameter int IDX_W   = 3
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [2:0]          req_action,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output tcfsm_pkg::cmd_type  cmd,
   output logic [IDX_W-1:0]    rd_addr,
   input  tcfsm_pkg::stat_type st
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   tcfsm_pkg::ctl_state_type state_ff, state_in;
   logic [CNT_W-1:0]         iss_ff, iss_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcfsm_pkg::CTL_IDLE;
         iss_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      cmd          = '0;
      rd_addr      = iss_ff[IDX_W-1:0];
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         tcfsm_pkg::CTL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               iss_in      = '0;
               unique case (req_action)
                  tcfsm_pkg::ACT_OPEN, tcfsm_pkg::ACT_SEGMENT,
                  tcfsm_pkg::ACT_TICK, tcfsm_pkg::ACT_LINKDOWN: state_in = tcfsm_pkg::CTL_SCAN;
                  tcfsm_pkg::ACT_LISTEN, tcfsm_pkg::ACT_CLOSE:  state_in = tcfsm_pkg::CTL_DIRECT;
                  default:                                      state_in = tcfsm_pkg::CTL_POST;
               endcase
            end
         end
         tcfsm_pkg::CTL_SCAN: begin
            cmd.chk_en = 1'b1;
            if (st.scan_done) begin
               state_in = tcfsm_pkg::CTL_POST;
            end else if (iss_ff < CNT_W'(ENTRIES)) begin
               cmd.rd_en = 1'b1;
               iss_in    = iss_ff + CNT_W'(1);
            end
         end
         tcfsm_pkg::CTL_DIRECT: begin
            cmd.direct = 1'b1;
            state_in   = tcfsm_pkg::CTL_POST;
         end
         tcfsm_pkg::CTL_POST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tcfsm_pkg::CTL_IDLE;
            end
         end
         default: state_in = tcfsm_pkg::CTL_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ design/tcfsm_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcfsm_datapath
// Connection table storage, per-entry evaluation, timeout register and
// result registers.
// ----------------------------------------------------------------------------
module tcfsm_datapath #(
   parameter int ENTRIES = 8,
   parameter int IDX_W   = 3
) (
   input  wire                  clock,
   input  wire                  reset,
   input  tcfsm_pkg::cmd_type   cmd,
   input  wire  [IDX_W-1:0]     rd_addr,
   output tcfsm_pkg::stat_type  st,
   input  tcfsm_pkg::item_type  req_item,
   input  wire                  csr_we,
   input  wire  [15:0]          csr_wdata,
   output tcfsm_pkg::res_type   rsp
);

   localparam int SW = (IDX_W > 3) ? IDX_W : 3;

   // flop state, cleared by reset
   logic                      used_ff  [ENTRIES];
   tcfsm_pkg::conn_state_type cstate_ff[ENTRIES];

   // table memories, contents undefined until written
   logic [15:0] sp_mem[ENTRIES];
   logic [15:0] cp_mem[ENTRIES];
   logic [15:0] tm_mem[ENTRIES];

   logic [15:0]         sp_q_ff, tm_q_ff;
   logic [IDX_W-1:0]    q_idx_ff;
   logic                q_vld_ff;
   logic [15:0]         ticks_ff;
   tcfsm_pkg::item_type item_ff;
   tcfsm_pkg::res_type  res_ff, rsp_ff;

   logic                      used_we, used_wd;
   logic                      cs_we;
   tcfsm_pkg::conn_state_type cs_wd;
   logic                      sp_we, cp_we, tm_we;
   logic [15:0]               cp_wd, tm_wd;
   logic                      hit, last, in_range;
   logic                      res_we;
   tcfsm_pkg::res_type        res_wd;
   logic [IDX_W-1:0]          k_scan, k_dir, wr_idx;
   logic [SW-1:0]             sidx_w;
   logic                      u;
   tcfsm_pkg::conn_state_type s;
   logic [15:0]               load_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= 16'd1;
      end else if (csr_we) begin
         ticks_ff <= csr_wdata;
      end
   end

   assign load_val = (ticks_ff == 16'd0) ? 16'd1 : ticks_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_item;
      end
   end

   // registered table read
   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else begin
         q_vld_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      q_idx_ff <= rd_addr;
      if (cmd.rd_en) begin
         sp_q_ff <= sp_mem[rd_addr];
         tm_q_ff <= tm_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sp_we) begin
         sp_mem[wr_idx] <= item_ff.local_port;
      end
      if (cp_we) begin
         cp_mem[wr_idx] <= cp_wd;
      end
      if (tm_we) begin
         tm_mem[wr_idx] <= tm_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            used_ff[i]   <= 1'b0;
            cstate_ff[i] <= tcfsm_pkg::CS_CLOSED;
         end
      end else begin
         if (used_we) begin
            used_ff[wr_idx] <= used_wd;
         end
         if (cs_we) begin
            cstate_ff[wr_idx] <= cs_wd;
         end
      end
   end

   always_comb begin
      sidx_w   = SW'(item_ff.socket_index);
      k_dir    = sidx_w[IDX_W-1:0];
      k_scan   = q_idx_ff;
      in_range = (32'(item_ff.socket_index) < 32'(ENTRIES));
      wr_idx   = cmd.direct ? k_dir : k_scan;
      u        = used_ff[wr_idx];
      s        = cstate_ff[wr_idx];
      last     = (q_idx_ff == IDX_W'(ENTRIES - 1));

      used_we = 1'b0;
      used_wd = 1'b0;
      cs_we   = 1'b0;
      cs_wd   = tcfsm_pkg::CS_CLOSED;
      sp_we   = 1'b0;
      cp_we   = 1'b0;
      cp_wd   = 16'd0;
      tm_we   = 1'b0;
      tm_wd   = 16'd0;
      hit     = 1'b0;
      res_we  = 1'b0;
      res_wd  = '0;

      if (cmd.chk_en && q_vld_ff) begin
         unique case (item_ff.action)
            tcfsm_pkg::ACT_OPEN: begin
               if (!u) begin
                  hit     = 1'b1;
                  used_we = 1'b1;
                  used_wd = 1'b1;
                  sp_we   = 1'b1;
                  cp_we   = 1'b1;
                  cs_we   = 1'b1;
                  tm_we   = 1'b1;
                  res_wd.entry_index = 3'(k_scan);
               end
            end
            tcfsm_pkg::ACT_SEGMENT: begin
               if (u && sp_q_ff == item_ff.seg_dest_port) begin
                  hit = 1'b1;
                  res_wd.entry_index = 3'(k_scan);
                  res_wd.entry_state = s;
                  if (item_ff.seg_type == tcfsm_pkg::SEG_SYN) begin
                     if (s == tcfsm_pkg::CS_LISTENING || s == tcfsm_pkg::CS_CONNECTED) begin
                        cs_we = 1'b1;
                        cs_wd = tcfsm_pkg::CS_CONNECTED;
                        cp_we = 1'b1;
                        cp_wd = item_ff.seg_src_port;
                        res_wd.entry_state     = tcfsm_pkg::CS_CONNECTED;
                        res_wd.reply_valid     = 1'b1;
                        res_wd.reply_type      = tcfsm_pkg::SEG_SYNACK;
                        res_wd.reply_src_port  = item_ff.seg_dest_port;
                        res_wd.reply_dest_port = item_ff.seg_src_port;
                     end else begin
                        res_wd.status = tcfsm_pkg::STS_WRONG;
                     end
                  end else if (item_ff.seg_type == tcfsm_pkg::SEG_FIN) begin
                     if (s == tcfsm_pkg::CS_CONNECTED || s == tcfsm_pkg::CS_CLOSEWAIT) begin
                        cs_we = 1'b1;
                        cs_wd = tcfsm_pkg::CS_CLOSEWAIT;
                        tm_we = 1'b1;
                        tm_wd = load_val;
                        res_wd.entry_state     = tcfsm_pkg::CS_CLOSEWAIT;
                        res_wd.reply_valid     = 1'b1;
                        res_wd.reply_type      = tcfsm_pkg::SEG_FINACK;
                        res_wd.reply_src_port  = item_ff.seg_dest_port;
                        res_wd.reply_dest_port = item_ff.seg_src_port;
                     end else begin
                        res_wd.status = tcfsm_pkg::STS_WRONG;
                     end
                  end
               end
            end
            tcfsm_pkg::ACT_TICK: begin
               if (u && tm_q_ff != 16'd0) begin
                  tm_we = 1'b1;
                  tm_wd = tm_q_ff - 16'd1;
                  if (tm_q_ff == 16'd1) begin
                     cs_we = 1'b1;
                     cs_wd = tcfsm_pkg::CS_CLOSED;
                  end
               end
            end
            tcfsm_pkg::ACT_LINKDOWN: begin
               if (u && (s == tcfsm_pkg::CS_LISTENING || s == tcfsm_pkg::CS_CONNECTED)) begin
                  cs_we = 1'b1;
                  cs_wd = tcfsm_pkg::CS_CLOSEWAIT;
                  tm_we = 1'b1;
                  tm_wd = load_val;
               end
            end
            default: ;
         endcase
         res_we = hit | last;
         // walk ran out: full table for open, unknown port for a segment
         if (!hit) begin
            if (item_ff.action == tcfsm_pkg::ACT_OPEN) begin
               res_wd.status = tcfsm_pkg::STS_FULL;
            end else if (item_ff.action == tcfsm_pkg::ACT_SEGMENT) begin
               res_wd.status = tcfsm_pkg::STS_NOENT;
            end
         end
      end else if (cmd.direct) begin
         res_we             = 1'b1;
         res_wd.entry_index = item_ff.socket_index;
         if (!in_range || !u) begin
            res_wd.status = tcfsm_pkg::STS_NOENT;
         end else if (item_ff.action == tcfsm_pkg::ACT_LISTEN) begin
            cs_we              = 1'b1;
            cs_wd              = tcfsm_pkg::CS_LISTENING;
            res_wd.entry_state = tcfsm_pkg::CS_LISTENING;
         end else if (s == tcfsm_pkg::CS_CLOSED) begin
            used_we = 1'b1;
            used_wd = 1'b0;
            tm_we   = 1'b1;
         end else begin
            res_wd.status      = tcfsm_pkg::STS_WRONG;
            res_wd.entry_state = s;
         end
      end
   end

   assign st.scan_done = cmd.chk_en & q_vld_ff & (hit | last);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_ff <= '0;
      end else if (res_we) begin
         res_ff <= res_wd;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

@@ design/transport_connection_table_fsm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// transport_connection_table_fsm
// Server-side connection table with open/listen/close and handshake handling.
// ----------------------------------------------------------------------------
// One request beat gives exactly one response beat. Requests are handled one
// at a time; a finished response waits in the output register while the next
// request is taken. Listen and close go straight to the addressed entry and
// unknown actions straight to the result; open and segment walk the table up
// to the entry found (all entries on a miss), and tick and link-down always
// walk every entry. An earlier response that still waits in the output
// register holds the result back. The next request is taken in the cycle after
// the response is loaded. The table walk visits one entry per cycle through
// the single read port of the port and timer memories. The close-wait timeout
// register may only be written while no request is in flight; csr_ready is
// always high.
// ----------------------------------------------------------------------------
module transport_connection_table_fsm #(
   parameter int ENTRIES = 8
) (
   input  wire         clock,
   input  wire         reset,
   // request
   input  wire         req_tvalid,
   output logic        req_tready,
   // [2:0] socket_index, [18:3] local_port, [21:19] seg_type,
   // [37:22] seg_src_port, [53:38] seg_dest_port, [55:54] zero
   input  wire  [55:0] req_tdata,
   // [2:0] action
   input  wire  [2:0]  req_tuser,
   // response
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [1:0] status, [4:2] entry_index, [6:5] entry_state, [7] reply_valid,
   // [10:8] reply_type, [26:11] reply_src_port, [42:27] reply_dest_port,
   // [47:43] zero
   output logic [47:0] rsp_tdata,
   // close-wait timeout register
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   tcfsm_pkg::cmd_type  cmd;
   tcfsm_pkg::stat_type st;
   tcfsm_pkg::item_type req_item;
   tcfsm_pkg::res_type  rsp;
   logic [IDX_W-1:0]    rd_addr;

   // unpack the request beat
   always_comb begin
      req_item.action        = req_tuser;
      req_item.socket_index  = req_tdata[2:0];
      req_item.local_port    = req_tdata[18:3];
      req_item.seg_type      = req_tdata[21:19];
      req_item.seg_src_port  = req_tdata[37:22];
      req_item.seg_dest_port = req_tdata[53:38];
   end

   assign csr_ready = 1'b1;

   tcfsm_ctrl #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .st         (st)
   );

   tcfsm_datapath #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .st        (st),
      .req_item  (req_item),
      .csr_we    (csr_valid),
      .csr_wdata (csr_data),
      .rsp       (rsp)
   );

   // pack the response beat
   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[1:0]   = rsp.status;
      rsp_tdata[4:2]   = rsp.entry_index;
      rsp_tdata[6:5]   = rsp.entry_state;
      rsp_tdata[7]     = rsp.reply_valid;
      rsp_tdata[10:8]  = rsp.reply_type;
      rsp_tdata[26:11] = rsp.reply_src_port;
      rsp_tdata[42:27] = rsp.reply_dest_port;
   end

endmodule
`default_nettype wire

@@ sim/transport_connection_table_fsm_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// transport_connection_table_fsm_tb
// Self-checking bench for the transport connection table.
// ----------------------------------------------------------------------------
// Request beats come from a backlog queue that the stimulus process fills in
// short chunks. Each chunk is planned from the bench's own copy of the table,
// so most traffic is open / listen / SYN / FIN / tick / close sessions that
// reach deep states; the rest is noise. Every accepted request is run through
// the table predictor and its response is queued. Each response beat is
// checked field by field against the oldest queued response. Both sides
// stall at random. The close-wait timeout is rewritten between phases, with
// the block drained first.
// ----------------------------------------------------------------------------
module transport_connection_table_fsm_tb;

   localparam int ENTRIES = 8;
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;
   localparam logic [2:0] SEG_DATA   = 3'd4;
   localparam logic [2:0] SEG_TOP    = 3'd7;
   localparam int DRAIN_CYCLES = 20;   // well past the table walk

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [55:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [15:0] csr_data = '0;

   transport_connection_table_fsm #(.ENTRIES(ENTRIES)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // bench copy of the table
   logic                      tbl_used  [ENTRIES];
   logic [15:0]               tbl_port  [ENTRIES];
   logic [15:0]               tbl_peer  [ENTRIES];
   tcfsm_pkg::conn_state_type tbl_state [ENTRIES];
   logic [15:0]               tbl_timer [ENTRIES];
   logic [15:0]               cw_ticks;

   tcfsm_pkg::item_type req_backlog [$];
   tcfsm_pkg::res_type  awaited_rsp [$];
   logic        req_beat_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned ready_hold = 0;
   int unsigned ready_stall;
   logic        calm = 1'b0;      // no idling on either side while set
   int          mismatch_count = 0;
   int          planned = 0;
   logic [15:0] port_pool [4];

   tcfsm_pkg::item_type sent_item;
   tcfsm_pkg::item_type seen_item;
   tcfsm_pkg::res_type  want_res;
   tcfsm_pkg::res_type  got_res;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

   // Outcome of one request on the bench table; updates the table as it goes.
   function automatic tcfsm_pkg::res_type table_outcome(tcfsm_pkg::item_type it);
      tcfsm_pkg::res_type r;
      int                 hit;
      int                 s;
      logic [15:0]        reload;
      r = '0;
      hit = -1;
      s = int'(it.socket_index);
      reload = (cw_ticks == 16'd0) ? 16'd1 : cw_ticks;
      case (it.action)
         tcfsm_pkg::ACT_OPEN: begin
            for (int i = 0; i < ENTRIES; i++)
               if (!tbl_used[i] && hit < 0) hit = i;
            if (hit < 0) begin
               r.status = tcfsm_pkg::STS_FULL;
            end else begin
               tbl_used[hit]  = 1'b1;
               tbl_port[hit]  = it.local_port;
               tbl_peer[hit]  = 16'd0;
               tbl_state[hit] = tcfsm_pkg::CS_CLOSED;
               tbl_timer[hit] = 16'd0;
               r.entry_index  = 3'(hit);
               r.entry_state  = tcfsm_pkg::CS_CLOSED;
            end
         end
         tcfsm_pkg::ACT_LISTEN, tcfsm_pkg::ACT_CLOSE: begin
            r.entry_index = it.socket_index;
            if (s >= ENTRIES || !tbl_used[s]) begin
               r.status = tcfsm_pkg::STS_NOENT;
            end else if (it.action == tcfsm_pkg::ACT_LISTEN) begin
               // a running close-wait timer is left alone
               tbl_state[s]  = tcfsm_pkg::CS_LISTENING;
               r.entry_state = tcfsm_pkg::CS_LISTENING;
            end else if (tbl_state[s] == tcfsm_pkg::CS_CLOSED) begin
               tbl_used[s]  = 1'b0;
               tbl_timer[s] = 16'd0;
            end else begin
               r.status      = tcfsm_pkg::STS_WRONG;
               r.entry_state = tbl_state[s];
            end
         end
         tcfsm_pkg::ACT_SEGMENT: begin
            for (int i = 0; i < ENTRIES; i++)
               if (tbl_used[i] && tbl_port[i] == it.seg_dest_port && hit < 0) hit = i;
            if (hit < 0) begin
               r.status = tcfsm_pkg::STS_NOENT;
            end else begin
               r.entry_index = 3'(hit);
               r.entry_state = tbl_state[hit];
               if (it.seg_type == tcfsm_pkg::SEG_SYN) begin
                  if (tbl_state[hit] == tcfsm_pkg::CS_LISTENING ||
                      tbl_state[hit] == tcfsm_pkg::CS_CONNECTED) begin
                     tbl_state[hit]    = tcfsm_pkg::CS_CONNECTED;
                     tbl_peer[hit]     = it.seg_src_port;
                     r.entry_state     = tcfsm_pkg::CS_CONNECTED;
                     r.reply_valid     = 1'b1;
                     r.reply_type      = tcfsm_pkg::SEG_SYNACK;
                     r.reply_src_port  = it.seg_dest_port;
                     r.reply_dest_port = it.seg_src_port;
                  end else begin
                     r.status = tcfsm_pkg::STS_WRONG;
                  end
               end else if (it.seg_type == tcfsm_pkg::SEG_FIN) begin
                  if (tbl_state[hit] == tcfsm_pkg::CS_CONNECTED ||
                      tbl_state[hit] == tcfsm_pkg::CS_CLOSEWAIT) begin
                     tbl_state[hit]    = tcfsm_pkg::CS_CLOSEWAIT;
                     tbl_timer[hit]    = reload;
                     r.entry_state     = tcfsm_pkg::CS_CLOSEWAIT;
                     r.reply_valid     = 1'b1;
                     r.reply_type      = tcfsm_pkg::SEG_FINACK;
                     r.reply_src_port  = it.seg_dest_port;
                     r.reply_dest_port = it.seg_src_port;
                  end else begin
                     r.status = tcfsm_pkg::STS_WRONG;
                  end
               end
            end
         end
         tcfsm_pkg::ACT_TICK: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_used[i] && tbl_timer[i] != 16'd0) begin
                  tbl_timer[i] = tbl_timer[i] - 16'd1;
                  if (tbl_timer[i] == 16'd0) tbl_state[i] = tcfsm_pkg::CS_CLOSED;
               end
            end
         end
         tcfsm_pkg::ACT_LINKDOWN: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (tbl_used[i] &&
                   (tbl_state[i] == tcfsm_pkg::CS_LISTENING ||
                    tbl_state[i] == tcfsm_pkg::CS_CONNECTED)) begin
                  tbl_state[i] = tcfsm_pkg::CS_CLOSEWAIT;
                  tbl_timer[i] = reload;
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_port();
      if ($urandom_range(0, 4) != 0) return port_pool[$urandom_range(0, 3)];
      return 16'($urandom);
   endfunction

   task automatic push_op(input logic [2:0] act, input logic [2:0] sidx,
                          input logic [15:0] port, input logic [2:0] stype,
                          input logic [15:0] src);
      tcfsm_pkg::item_type it;
      it.action        = act;
      it.socket_index  = sidx;
      it.local_port    = port;
      it.seg_type      = stype;
      it.seg_src_port  = src;
      it.seg_dest_port = port;
      req_backlog.push_back(it);
      if (act != ACT_SPARE6 && act != ACT_SPARE7) planned++;
   endtask

   task automatic push_noise();
      tcfsm_pkg::item_type it;
      int unsigned         r;
      r = $urandom_range(0, 19);
      it.action        = (r < 18) ? 3'(r % 6) : 3'(r - 12);
      it.socket_index  = 3'($urandom);
      it.local_port    = pick_port();
      it.seg_type      = 3'($urandom_range(0, 7));
      it.seg_src_port  = 16'($urandom);
      it.seg_dest_port = pick_port();
      req_backlog.push_back(it);
      if (it.action != ACT_SPARE6 && it.action != ACT_SPARE7) planned++;
   endtask

   // close every closed entry; with none, knock the link down and tick
   task automatic push_cleanup();
      int freed;
      int n;
      freed = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_used[i] && tbl_state[i] == tcfsm_pkg::CS_CLOSED) begin
            push_op(tcfsm_pkg::ACT_CLOSE, 3'(i), pick_port(), 3'($urandom), 16'($urandom));
            freed++;
         end
      end
      if (freed == 0) begin
         push_op(tcfsm_pkg::ACT_LINKDOWN, 3'($urandom), pick_port(), 3'($urandom),
                 16'($urandom));
         n = (cw_ticks <= 16'd5) ? 5 : 2;
         repeat (n) push_op(tcfsm_pkg::ACT_TICK, 3'($urandom), pick_port(), 3'($urandom),
                            16'($urandom));
      end
   endtask

   // Plans one chunk from the current table; called with the sender idle,
   // so every earlier beat has already gone through the predictor.
   task automatic plan_chunk();
      int          f;
      int          u;
      int          n;
      int          nused;
      int          used_list [ENTRIES];
      logic [15:0] p;
      f = -1;
      nused = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!tbl_used[i] && f < 0) f = i;
         if (tbl_used[i]) begin
            used_list[nused] = i;
            nused++;
         end
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (f < 0) begin
               if ($urandom_range(0, 2) == 0)
                  push_op(tcfsm_pkg::ACT_OPEN, 3'($urandom), pick_port(), 3'($urandom),
                          16'($urandom));
               push_cleanup();
            end else begin
               // open / listen / SYN / FIN / wait out close-wait / close
               p = pick_port();
               push_op(tcfsm_pkg::ACT_OPEN, 3'($urandom), p, 3'($urandom), 16'($urandom));
               if ($urandom_range(0, 9) != 0)
                  push_op(tcfsm_pkg::ACT_LISTEN, 3'(f), 16'($urandom), 3'($urandom),
                          16'($urandom));
               push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), p, tcfsm_pkg::SEG_SYN,
                       16'($urandom));
               if ($urandom_range(0, 2) == 0)
                  push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), p, tcfsm_pkg::SEG_SYN,
                          16'($urandom));
               if ($urandom_range(0, 3) == 0)
                  push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), p, 3'($urandom_range(0, 7)),
                          16'($urandom));
               if ($urandom_range(0, 4) == 0)
                  push_op(tcfsm_pkg::ACT_LINKDOWN, 3'($urandom), 16'($urandom), 3'($urandom),
                          16'($urandom));
               else
                  push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), p, tcfsm_pkg::SEG_FIN,
                          16'($urandom));
               if ($urandom_range(0, 2) == 0)
                  push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), p, tcfsm_pkg::SEG_FIN,
                          16'($urandom));
               if (cw_ticks <= 16'd6)
                  n = (cw_ticks == 16'd0) ? 1 : int'(cw_ticks);
               else
                  n = $urandom_range(1, 3);
               if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
               repeat (n) push_op(tcfsm_pkg::ACT_TICK, 3'($urandom), 16'($urandom),
                                  3'($urandom), 16'($urandom));
               push_op(tcfsm_pkg::ACT_CLOSE, 3'(f), 16'($urandom), 3'($urandom),
                       16'($urandom));
            end
         end
         4, 5: begin
            if (nused == 0) begin
               push_noise();
            end else begin
               u = used_list[$urandom_range(0, nused - 1)];
               case ($urandom_range(0, 5))
                  0: push_op(tcfsm_pkg::ACT_LISTEN, 3'(u), 16'($urandom), 3'($urandom),
                             16'($urandom));
                  1: push_op(tcfsm_pkg::ACT_CLOSE, 3'(u), 16'($urandom), 3'($urandom),
                             16'($urandom));
                  2: push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), tbl_port[u],
                             tcfsm_pkg::SEG_SYN, 16'($urandom));
                  3: push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), tbl_port[u],
                             tcfsm_pkg::SEG_FIN, 16'($urandom));
                  4: push_op(tcfsm_pkg::ACT_SEGMENT, 3'($urandom), tbl_port[u],
                             3'($urandom_range(0, 7)), 16'($urandom));
                  default: push_op(tcfsm_pkg::ACT_TICK, 3'($urandom), 16'($urandom),
                                   3'($urandom), 16'($urandom));
               endcase
            end
         end
         6: push_cleanup();
         default: repeat ($urandom_range(1, 3)) push_noise();
      endcase
   endtask

   task automatic wait_sender_idle();
      @(posedge clock);
      while (req_backlog.size() != 0 || req_tvalid) @(posedge clock);
   endtask

   // hold the sender until every awaited response beat is back
   task automatic drain();
      wait_sender_idle();
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int quota);
      port_pool[0] = 16'h0000;
      port_pool[1] = 16'hFFFF;
      port_pool[2] = 16'($urandom);
      port_pool[3] = 16'($urandom);
      planned = 0;
      while (planned < quota) begin
         wait_sender_idle();
         calm = ($urandom_range(0, 7) == 0);
         plan_chunk();
      end
   endtask

   // request driver: new beats at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (req_tvalid && !req_beat_taken) begin
         // beat still on offer
      end else if (send_gap != 0) begin
         req_tvalid <= 1'b0;
         send_gap   <= send_gap - 1;
      end else if (req_backlog.size() != 0) begin
         sent_item  = req_backlog.pop_front();
         req_tuser  <= sent_item.action;
         req_tdata  <= {2'b00, sent_item.seg_dest_port, sent_item.seg_src_port,
                        sent_item.seg_type, sent_item.local_port, sent_item.socket_index};
         req_tvalid <= 1'b1;
         send_gap   <= calm ? 0 : pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         ready_stall = pick_gap();
         rsp_tready <= (ready_stall == 0);
         ready_hold <= (ready_stall == 0) ? 0 : ready_stall - 1;
      end
   end

   // monitor: predicts on request beats, checks response beats
   always @(posedge clock) begin
      if (reset) begin
         req_beat_taken <= 1'b0;
         cw_ticks = 16'd1;
         for (int i = 0; i < ENTRIES; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_port[i]  = 16'd0;
            tbl_peer[i]  = 16'd0;
            tbl_state[i] = tcfsm_pkg::CS_CLOSED;
            tbl_timer[i] = 16'd0;
         end
      end else begin
         req_beat_taken <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) cw_ticks = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got_res.status          = tcfsm_pkg::status_type'(rsp_tdata[1:0]);
            got_res.entry_index     = rsp_tdata[4:2];
            got_res.entry_state     = tcfsm_pkg::conn_state_type'(rsp_tdata[6:5]);
            got_res.reply_valid     = rsp_tdata[7];
            got_res.reply_type      = rsp_tdata[10:8];
            got_res.reply_src_port  = rsp_tdata[26:11];
            got_res.reply_dest_port = rsp_tdata[42:27];
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response beat with none awaited: %h", $realtime, rsp_tdata);
            end else begin
               want_res = awaited_rsp.pop_front();
               if (got_res.status != want_res.status ||
                   got_res.entry_index != want_res.entry_index ||
                   got_res.entry_state != want_res.entry_state ||
                   got_res.reply_valid != want_res.reply_valid ||
                   got_res.reply_type != want_res.reply_type ||
                   got_res.reply_src_port != want_res.reply_src_port ||
                   got_res.reply_dest_port != want_res.reply_dest_port) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch sts/idx/st/rv/rt/rs/rd", $realtime);
                     $display("   exp %0d/%0d/%0d/%0d/%0d/%h/%h",
                              want_res.status, want_res.entry_index,
                              want_res.entry_state, want_res.reply_valid, want_res.reply_type,
                              want_res.reply_src_port, want_res.reply_dest_port);
                     $display("   got %0d/%0d/%0d/%0d/%0d/%h/%h",
                              got_res.status, got_res.entry_index, got_res.entry_state,
                              got_res.reply_valid, got_res.reply_type,
                              got_res.reply_src_port, got_res.reply_dest_port);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            seen_item.action        = req_tuser;
            seen_item.socket_index  = req_tdata[2:0];
            seen_item.local_port    = req_tdata[18:3];
            seen_item.seg_type      = req_tdata[21:19];
            seen_item.seg_src_port  = req_tdata[37:22];
            seen_item.seg_dest_port = req_tdata[53:38];
            awaited_rsp.push_back(table_outcome(seen_item));
         end
      end
   end

   initial begin
      @(negedge reset);
      @(posedge clock);

      // directed part, timeout at its reset value of one tick
      // empty table
      push_op(tcfsm_pkg::ACT_TICK, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      push_op(tcfsm_pkg::ACT_LINKDOWN, 3'd7, 16'hFFFF, SEG_TOP, 16'hFFFF);
      push_op(ACT_SPARE6, 3'd3, 16'h5A5A, tcfsm_pkg::SEG_FIN, 16'hA5A5);
      push_op(ACT_SPARE7, 3'd4, 16'hA5A5, SEG_DATA, 16'h5A5A);
      // missing entries
      push_op(tcfsm_pkg::ACT_LISTEN, 3'd7, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      push_op(tcfsm_pkg::ACT_CLOSE, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      // no such port
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h1234, tcfsm_pkg::SEG_SYN, 16'h4321);
      // entries 0 and 1
      push_op(tcfsm_pkg::ACT_OPEN, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      push_op(tcfsm_pkg::ACT_OPEN, 3'd0, 16'hFFFF, tcfsm_pkg::SEG_SYN, 16'h0000);
      // SYN and FIN while closed
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'hFFFF);
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h0000, tcfsm_pkg::SEG_FIN, 16'hFFFF);
      push_op(tcfsm_pkg::ACT_LISTEN, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      // close not closed
      push_op(tcfsm_pkg::ACT_CLOSE, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      // SYNACK
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd7, 16'h0000, tcfsm_pkg::SEG_SYN, 16'hFFFF);
      // entry 1 still closed
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'hFFFF, tcfsm_pkg::SEG_SYN, 16'h0000);
      // FINACK
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h0000, tcfsm_pkg::SEG_FIN, 16'hFFFF);
      // SYN and FIN in close-wait
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h0000, tcfsm_pkg::SEG_FIN, 16'h0000);
      // other segment types
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h0000, SEG_DATA, 16'hFFFF);
      push_op(tcfsm_pkg::ACT_SEGMENT, 3'd0, 16'h0000, SEG_TOP, 16'hFFFF);
      // close-wait expires
      push_op(tcfsm_pkg::ACT_TICK, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      push_op(tcfsm_pkg::ACT_CLOSE, 3'd0, 16'h0000, tcfsm_pkg::SEG_SYN, 16'h0000);
      repeat (ENTRIES - 1)
         push_op(tcfsm_pkg::ACT_OPEN, 3'd0, 16'($urandom), tcfsm_pkg::SEG_SYN, 16'h0000);
      // table full
      push_op(tcfsm_pkg::ACT_OPEN, 3'd0, 16'h7777, tcfsm_pkg::SEG_SYN, 16'h0000);

      // random phases over several timeouts, zero and the top value among them
      write_timeout(16'd4);
      run_phase(200);
      write_timeout(16'd0);
      run_phase(150);
      write_timeout(16'd1);
      run_phase(150);
      write_timeout(16'd2);
      run_phase(150);
      // entries loaded with the top value do not expire within a phase, so this one is last
      write_timeout(16'hFFFF);
      run_phase(100);

      drain();
      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
